// ----- sv/receive_reorder_window_core_macros.svh -----
// Assertion macros shared by the reorder window modules.
// Each expects clk and rst_n in scope.
`ifndef RECEIVE_REORDER_WINDOW_CORE_MACROS_SVH
`define RECEIVE_REORDER_WINDOW_CORE_MACROS_SVH

// Same-cycle implication
`define RRW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RRW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rrw_pkg.sv -----
`default_nettype none
package rrw_pkg;

    localparam int WIN_SIZE  = 32;
    localparam int SEQ_W     = 32;
    localparam int HANDLE_W  = 16;
    localparam int IDX_BITS  = $clog2(WIN_SIZE);
    localparam int CNT_BITS  = $clog2(WIN_SIZE + 1);

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUP       = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD       = 3'd3,
        ST_DELIVERED = 3'd4,
        ST_NONE      = 3'd5
    } status_t;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SEQ_W-1:0]    seq_num;
        logic [HANDLE_W-1:0] handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [SEQ_W-1:0]    out_seq;
        logic [HANDLE_W-1:0] out_handle;
        logic                sack_valid;
        logic [SEQ_W-1:0]    last_ack;
        logic                last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic add;    // evaluate and answer an add beat
        logic step;   // deliver the head slot, or report nothing ready
        logic first;  // step is the first of a drain
    } rrw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic step_last;  // a step now gives the final result of the drain
    } rrw_stat_t;

endpackage
`default_nettype wire

// ----- sv/rrw_ctrl.sv -----
`default_nettype none
module rrw_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_func,
    output logic                   in_stall,
    output rrw_pkg::rrw_cmd_t      cmd,
    input  wire rrw_pkg::rrw_stat_t stat
);
    import rrw_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a beat only between drains and when the result can be parked
    assign in_stall = (state_reg != S_IDLE) || !stat.out_free;
    assign accept   = in_valid && !in_stall;

    // Issue commands and pick the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == FUNC_ADD)
                    begin
                        cmd.add = 1'b1;
                    end
                    else
                    begin
                        cmd.step  = 1'b1;
                        cmd.first = 1'b1;
                        if (!stat.step_last)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.step_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/rrw_dpath.sv -----
`default_nettype none
`include "receive_reorder_window_core_macros.svh"
module rrw_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rrw_pkg::in_item_t  in_data,
    input  wire rrw_pkg::rrw_cmd_t  cmd,
    output rrw_pkg::rrw_stat_t      stat,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rrw_pkg::out_item_t      out_data
);
    import rrw_pkg::*;

    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    logic [SEQ_W-1:0]    base_reg;
    logic [SEQ_W-1:0]    base_next;
    logic [WIN_SIZE-1:0] slot_valid_reg;
    logic [WIN_SIZE-1:0] slot_valid_next;
    logic [HANDLE_W-1:0] slot_handle [WIN_SIZE];
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_after;
    logic                out_valid_reg;
    out_item_t           out_reg;
    out_item_t           result;

    logic [IDX_BITS-1:0] add_idx;
    logic [IDX_BITS-1:0] head_idx;
    logic [IDX_BITS-1:0] next_idx;
    logic [SEQ_W-1:0]    base_inc;
    logic [SEQ_W-1:0]    add_diff;
    logic                head_ready;
    logic                store;
    logic                deliver;

    assign add_idx    = in_data.seq_num[IDX_BITS-1:0];
    assign head_idx   = base_reg[IDX_BITS-1:0];
    assign base_inc   = base_reg + SEQ_W'(1);
    assign next_idx   = base_inc[IDX_BITS-1:0];
    assign add_diff   = in_data.seq_num - base_reg;
    assign head_ready = slot_valid_reg[head_idx] && (base_reg != SEQ_MAX);
    assign cnt_after  = cmd.first ? CNT_BITS'(1) : cnt_reg + CNT_BITS'(1);

    // Report output space and whether this step ends the drain
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.step_last = !head_ready || !slot_valid_reg[next_idx]
                            || (base_inc == SEQ_MAX)
                            || (cnt_after == CNT_BITS'(WIN_SIZE));

    // Classify an add, or form the next drain result
    always_comb
    begin
        result            = '0;
        result.last_ack   = base_reg - SEQ_W'(1);
        result.last       = 1'b1;
        store             = 1'b0;
        deliver           = 1'b0;
        if (cmd.step)
        begin
            if (head_ready)
            begin
                // The delivered handle joins at the output register
                deliver           = 1'b1;
                result.status     = ST_DELIVERED;
                result.out_seq    = base_reg;
                result.last_ack   = base_reg;
                result.last       = stat.step_last;
            end
            else
            begin
                result.status = ST_NONE;
            end
        end
        else
        begin
            result.out_seq    = in_data.seq_num;
            result.out_handle = in_data.handle;
            if (in_data.seq_num == SEQ_MAX)
            begin
                result.status = ST_BAD;
            end
            else if (in_data.seq_num < base_reg)
            begin
                result.status     = ST_DUP;
                result.sack_valid = 1'b1;
            end
            else if (add_diff >= SEQ_W'(WIN_SIZE))
            begin
                result.status = ST_FULL;
            end
            else if (slot_valid_reg[add_idx])
            begin
                result.status     = ST_DUP;
                result.sack_valid = 1'b1;
            end
            else
            begin
                store             = cmd.add;
                result.status     = ST_STORED;
                result.out_handle = '0;
                result.sack_valid = 1'b1;
            end
        end
    end

    // Mark stored slots, free delivered ones, advance the base
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        base_next       = base_reg;
        if (store)
        begin
            slot_valid_next[add_idx] = 1'b1;
        end
        if (deliver)
        begin
            slot_valid_next[head_idx] = 1'b0;
            base_next                 = base_inc;
        end
    end

    // Hold window state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= SEQ_W'(1);
            slot_valid_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            base_reg       <= base_next;
            slot_valid_reg <= slot_valid_next;
            if (cmd.step)
            begin
                cnt_reg <= cnt_after;
            end
            if (cmd.add || cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload storage needs no reset; read the head handle on delivery
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            slot_handle[add_idx] <= in_data.handle;
        end
        if (deliver)
        begin
            out_reg <= {result.status, result.out_seq, slot_handle[head_idx],
                        result.sack_valid, result.last_ack, result.last};
        end
        else if (cmd.add || cmd.step)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `RRW_ASSERT_IMP(a_load_has_room, cmd.add || cmd.step, stat.out_free, "result loaded over a held one")
    `RRW_ASSERT_NXT(a_base_moves_on_step, !cmd.step, $stable(base_reg), "window base moved without a drain step")
    `RRW_ASSERT_NXT(a_head_freed, deliver, !slot_valid_reg[$past(head_idx)], "delivered slot still marked")
    `RRW_ASSERT_IMP(a_drain_bounded, 1'b1, cnt_reg <= CNT_BITS'(WIN_SIZE), "drain ran past the window size")

endmodule
`default_nettype wire

// ----- sv/receive_reorder_window_core.sv -----
// Receive reorder window over 32 slots keyed by sequence number. An add beat
// (func 0) is answered with one result in the cycle after it is taken: stored,
// duplicated (below the base or slot taken), window full, or bad number for
// the all-ones sequence number. A drain beat (func 1) delivers every stored
// handle contiguous from the window base, up to 32, one result per cycle while
// the output is not stalled, walking the single head-slot read of the window;
// an empty drain gives one "nothing ready" result. The final result of each
// beat carries last, and every result carries last_ack, the base minus one
// after that result. The input stalls for the whole drain. Base resets to 1
// and all slots to empty.
`default_nettype none
module receive_reorder_window_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rrw_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rrw_pkg::out_item_t     out_data
);
    import rrw_pkg::*;

    rrw_cmd_t  cmd;
    rrw_stat_t stat;

    // Sequence adds and drain steps
    rrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Window storage and result formation
    rrw_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ----- verif/receive_reorder_window_checker.sv -----
`timescale 1ns / 100ps
module receive_reorder_window_checker
    import rrw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire in_item_t         in_data,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire out_item_t        out_data,
    output int                    fail_count,
    output int                    result_count,
    output int                    awaited,
    output logic [SEQ_W-1:0]      base_now
);

    localparam int REPORT_CAP = 100;

    // Shadow of the window: base, slot occupancy and stored handles
    logic [SEQ_W-1:0]    win_base;
    logic                slot_held   [WIN_SIZE];
    logic [HANDLE_W-1:0] slot_handle [WIN_SIZE];

    // Results still owed by the block, oldest first
    out_item_t           owed_results [$];

    int                  fails   = 0;
    int                  results = 0;

    // Append one owed result at the young end
    task automatic owe_result(input out_item_t res);
        owed_results = {owed_results, res};
    endtask

    // Work out every result beat that one accepted input beat causes
    task automatic predict_beat(input in_item_t beat);
        logic [IDX_BITS-1:0] slot;
        out_item_t           res;
        int                  delivered;
        res      = '0;
        res.last = 1'b1;
        if (beat.func == FUNC_ADD)
        begin
            slot           = beat.seq_num[IDX_BITS-1:0];
            res.out_seq    = beat.seq_num;
            res.out_handle = beat.handle;
            if (beat.seq_num == '1)
                res.status = ST_BAD;
            else if (beat.seq_num < win_base)
            begin
                res.status     = ST_DUP;
                res.sack_valid = 1'b1;
            end
            else if (beat.seq_num - win_base >= WIN_SIZE)
                res.status = ST_FULL;
            else if (slot_held[slot])
            begin
                res.status     = ST_DUP;
                res.sack_valid = 1'b1;
            end
            else
            begin
                slot_held[slot]   = 1'b1;
                slot_handle[slot] = beat.handle;
                res.status        = ST_STORED;
                res.out_handle    = '0;
                res.sack_valid    = 1'b1;
            end
            res.last_ack = win_base - SEQ_W'(1);
            owe_result(res);
        end
        else
        begin
            // Walk contiguous slots from the base, never past the top number
            delivered = 0;
            while (delivered < WIN_SIZE && win_base != '1
                   && slot_held[win_base[IDX_BITS-1:0]])
            begin
                slot            = win_base[IDX_BITS-1:0];
                res.status      = ST_DELIVERED;
                res.out_seq     = win_base;
                res.out_handle  = slot_handle[slot];
                res.sack_valid  = 1'b0;
                res.last        = 1'b0;
                slot_held[slot] = 1'b0;
                win_base        = win_base + SEQ_W'(1);
                res.last_ack    = win_base - SEQ_W'(1);
                owe_result(res);
                delivered++;
            end
            if (delivered == 0)
            begin
                res          = '0;
                res.status   = ST_NONE;
                res.last     = 1'b1;
                res.last_ack = win_base - SEQ_W'(1);
                owe_result(res);
            end
            else
            begin
                // Mark the final delivery of this drain
                res      = owed_results.pop_back();
                res.last = 1'b1;
                owe_result(res);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
        if (got !== want)
        begin
            fails++;
            if (fails <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // Predict on accepted input beats, compare on accepted result beats
    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t want;
        if (!rst_n)
        begin
            win_base = SEQ_W'(1);
            foreach (slot_held[i])
                slot_held[i] = 1'b0;
            owed_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_beat(in_data);
            if (out_valid && !out_stall)
            begin
                results++;
                if (owed_results.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_CAP)
                        $display("%0t: result beat with nothing expected, expected none, actual %h",
                                 $time, out_data);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("status", SEQ_W'(want.status), SEQ_W'(out_data.status));
                    check_field("out_seq", want.out_seq, out_data.out_seq);
                    check_field("out_handle", SEQ_W'(want.out_handle),
                                SEQ_W'(out_data.out_handle));
                    check_field("sack_valid", SEQ_W'(want.sack_valid),
                                SEQ_W'(out_data.sack_valid));
                    check_field("last_ack", want.last_ack, out_data.last_ack);
                    check_field("last", SEQ_W'(want.last), SEQ_W'(out_data.last));
                end
            end
        end
        fail_count   <= fails;
        result_count <= results;
        awaited      <= owed_results.size();
        base_now     <= win_base;
    end

endmodule

// ----- verif/receive_reorder_window_core_tb.sv -----
`timescale 1ns / 100ps
module receive_reorder_window_core_tb;
    import rrw_pkg::*;

    // Worst case: ~280 beats of 32 results each, every result stalled, plus the
    // hold-off; taken several times over
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BEATS  = 28;
    localparam int SETTLE       = 40;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    int               fail_count;
    int               result_count;
    int               awaited;
    logic [SEQ_W-1:0] base_now;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int beats_sent    = 0;
    int drains_sent   = 0;

    receive_reorder_window_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    receive_reorder_window_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .result_count (result_count),
        .awaited      (awaited),
        .base_now     (base_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stall, or a long hold-off when one is requested
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Abort a hung run
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: cycle limit of %0d reached with %0d results outstanding",
                 $time, CYCLE_LIMIT, awaited);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one beat until taken; a relative number is added to the current base
    task automatic send_beat(input logic func, input logic [SEQ_W-1:0] seq,
                             input logic [HANDLE_W-1:0] hnd, input bit rel);
        in_item_t beat;
        @(negedge clk);
        if (rel)
            seq = seq + base_now;
        beat.func    = func;
        beat.seq_num = seq;
        beat.handle  = hnd;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        if (func == FUNC_DRAIN)
            drains_sent++;
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    // Mostly adds near the base and filled runs followed by a drain; the rest is noise
    task automatic random_mix(input int count);
        int sent;
        int roll;
        int span;
        int pick;
        int swap;
        int i;
        int order [WIN_SIZE];
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                // fill a run from the base in shuffled order, then drain it
                span = $urandom_range(1, WIN_SIZE);
                for (i = 0; i < span; i++)
                    order[i] = i;
                for (i = span - 1; i > 0; i--)
                begin
                    pick        = $urandom_range(i);
                    swap        = order[i];
                    order[i]    = order[pick];
                    order[pick] = swap;
                end
                for (i = 0; i < span; i++)
                    send_beat(FUNC_ADD, order[i], HANDLE_W'($urandom), 1'b1);
                send_beat(FUNC_DRAIN, $urandom, HANDLE_W'($urandom), 1'b0);
                sent += span + 1;
            end
            else
            begin
                if (roll < 50)
                    send_beat(FUNC_ADD, $urandom_range(WIN_SIZE - 1), HANDLE_W'($urandom),
                              1'b1);
                else if (roll < 57)
                    send_beat(FUNC_ADD, WIN_SIZE + $urandom_range(8), HANDLE_W'($urandom),
                              1'b1);
                else if (roll < 64)
                    send_beat(FUNC_ADD, 32'd0 - 32'($urandom_range(1, 40)),
                              HANDLE_W'($urandom), 1'b1);
                else if (roll < 68)
                    send_beat(FUNC_ADD, '1, HANDLE_W'($urandom), 1'b0);
                else if (roll < 78)
                    send_beat(FUNC_ADD, $urandom, HANDLE_W'($urandom), 1'b0);
                else
                    send_beat(FUNC_DRAIN, $urandom, HANDLE_W'($urandom), 1'b0);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty drain, every reject, storing and partial drains
        send_beat(FUNC_DRAIN, '1, 16'hFFFF, 1'b0);
        send_beat(FUNC_ADD, 32'd0, 16'h1234, 1'b0);
        send_beat(FUNC_ADD, '1, 16'hFFFF, 1'b0);
        send_beat(FUNC_ADD, 32'd33, 16'h0F0F, 1'b0);
        send_beat(FUNC_ADD, 32'hFFFF_FFFE, 16'h00FF, 1'b0);
        send_beat(FUNC_ADD, 32'd32, 16'hFFFF, 1'b0);
        send_beat(FUNC_ADD, 32'd1, 16'h0000, 1'b0);
        send_beat(FUNC_ADD, 32'd1, 16'h5555, 1'b0);
        send_beat(FUNC_ADD, 32'd3, 16'hAAAA, 1'b0);
        send_beat(FUNC_DRAIN, 32'd0, 16'h0000, 1'b0);
        send_beat(FUNC_ADD, 32'd1, 16'h7777, 1'b0);
        send_beat(FUNC_ADD, 32'd2, 16'h1111, 1'b0);
        send_beat(FUNC_ADD, 32'd33, 16'h3333, 1'b0);
        send_beat(FUNC_DRAIN, 32'h8000_0000, 16'h8000, 1'b0);
        send_beat(FUNC_ADD, 32'd64, 16'h6464, 1'b0);
        send_beat(FUNC_ADD, 32'd35, 16'h3535, 1'b0);
        send_beat(FUNC_ADD, 32'd4, 16'h4444, 1'b0);
        send_beat(FUNC_DRAIN, 32'd0, 16'h0000, 1'b0);
        wait_drained();

        // Random traffic under each idle mix
        send_idle_pct = 0;
        stall_pct     = 0;
        random_mix(PHASE_BEATS);
        wait_drained();
        send_idle_pct = 51;
        stall_pct     = 0;
        random_mix(PHASE_BEATS);
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 51;
        random_mix(PHASE_BEATS);
        wait_drained();
        send_idle_pct = 24;
        stall_pct     = 24;
        random_mix(PHASE_BEATS);
        wait_drained();

        // Hold the result side off while adds keep coming, so the input backs up
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = HOLD_CYCLES;
        for (i = 0; i < 20; i++)
            send_beat(FUNC_ADD, $urandom_range(WIN_SIZE + 3), HANDLE_W'($urandom), 1'b1);
        send_beat(FUNC_DRAIN, $urandom, HANDLE_W'($urandom), 1'b0);
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d input beats (%0d drains); checked %0d result beats",
                 beats_sent, drains_sent, result_count);
        $display("Covered rejects, partial and full drains, four idle mixes, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && awaited == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
